@@ src/assert_macros.svh @@
// assertion macros shared by the hall indicator frame driver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define HIFD_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define HIFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define HIFD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/hifd_pkg.sv @@
// types, codes and segment tables of the hall indicator frame driver
package hifd_pkg;

   localparam int HALF_W     = 16;
   localparam int PULSE_W    = 16;
   localparam int TIMER_W    = 17;
   localparam int BIT_CNT_W  = 5;
   localparam int LAMP_W     = 6;
   localparam int LEFT_W     = 11;
   localparam int RIGHT_W    = 8;
   localparam int FRAME_BITS = LAMP_W + LEFT_W + RIGHT_W;

   localparam logic [2:0] FUNC_TICK  = 3'd0;
   localparam logic [2:0] FUNC_RAW   = 3'd1;
   localparam logic [2:0] FUNC_ARROW = 3'd2;
   localparam logic [2:0] FUNC_LAMP  = 3'd3;
   localparam logic [2:0] FUNC_FLOOR = 3'd4;
   localparam logic [2:0] FUNC_ASCII = 3'd5;
   localparam logic [2:0] FUNC_CLEAR = 3'd6;

   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   localparam logic [1:0] SEL_ANIM     = 2'd0;
   localparam logic [1:0] SEL_FAST     = 2'd1;
   localparam logic [1:0] SEL_OVERLOAD = 2'd2;
   localparam logic [1:0] SEL_OOS      = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BUSY  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic CSR_HALF_PERIOD  = 1'b0;
   localparam logic CSR_ENABLE_PULSE = 1'b1;

   localparam logic [LAMP_W-1:0]  LAMP_RESET = 6'b100000;
   localparam logic [LEFT_W-1:0]  LEFT_ALL   = 11'b11111111111;
   localparam logic [HALF_W-1:0]  HALF_RESET = 16'd10;
   localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd20;

   typedef struct packed {
      logic [2:0]         func;
      logic [LAMP_W-1:0]  raw_lamp;
      logic [LEFT_W-1:0]  raw_left;
      logic [RIGHT_W-1:0] raw_right;
      logic [1:0]         arrow_dir;
      logic [1:0]         lamp_select;
      logic               flag;
      logic signed [7:0]  floor_number;
      logic [7:0]         left_char;
      logic [7:0]         right_char;
   } req_type;

   typedef struct packed {
      logic       data_line;
      logic       clock_line;
      logic       enable_line;
      logic       busy_res;
      logic [1:0] status;
   } rsp_type;

   // decoded command handed from front to back
   typedef struct packed {
      logic                  cmd;
      logic                  floor_bad;
      logic                  use_raw;
      logic [FRAME_BITS-1:0] raw_frame;
      logic [LAMP_W-1:0]     lamp_mask;
      logic [LAMP_W-1:0]     lamp_val;
      logic                  left_we;
      logic [LEFT_W-1:0]     left_val;
      logic                  right_we;
      logic [RIGHT_W-1:0]    right_val;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [7:0] digit_seg(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h30;
         4'd2:    s = 8'hDB;
         4'd3:    s = 8'hCF;
         4'd4:    s = 8'hE6;
         4'd5:    s = 8'hED;
         4'd6:    s = 8'hFD;
         4'd7:    s = 8'h27;
         4'd8:    s = 8'hFF;
         4'd9:    s = 8'hEF;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] char_seg(input logic [7:0] c);
      logic [7:0] s;
      case (c) inside
         [8'h30:8'h39]: s = digit_seg(c[3:0]);
         8'h41: s = 8'hF7;
         8'h42: s = 8'h90;
         8'h43: s = 8'h39;
         8'h44: s = 8'h89;
         8'h45: s = 8'hF9;
         8'h46: s = 8'hF1;
         8'h47: s = 8'hBD;
         8'h48: s = 8'hF6;
         8'h49: s = 8'h01;
         8'h4A: s = 8'h1E;
         8'h4B: s = 8'h05;
         8'h4C: s = 8'h38;
         8'h4E: s = 8'h09;
         8'h4F: s = 8'h11;
         8'h50: s = 8'hF3;
         8'h51: s = 8'h21;
         8'h52: s = 8'hB7;
         8'h53: s = 8'h41;
         8'h54: s = 8'h81;
         8'h55: s = 8'h3E;
         8'h56: s = 8'h0F;
         8'h57: s = 8'h13;
         8'h58: s = 8'h0A;
         8'h59: s = 8'h12;
         8'h5A: s = 8'h22;
         8'h61: s = 8'hDF;
         8'h62: s = 8'hFC;
         8'h63: s = 8'hD8;
         8'h64: s = 8'hDE;
         8'h65: s = 8'hBB;
         8'h66: s = 8'h71;
         8'h67: s = 8'h0C;
         8'h68: s = 8'hF4;
         8'h69: s = 8'h14;
         8'h6A: s = 8'h24;
         8'h6B: s = 8'h44;
         8'h6D: s = 8'h84;
         8'h6E: s = 8'h0D;
         8'h6F: s = 8'hDC;
         8'h70: s = 8'h28;
         8'h71: s = 8'h48;
         8'h72: s = 8'hD0;
         8'h73: s = 8'h50;
         8'h74: s = 8'h90;
         8'h75: s = 8'h1C;
         8'h76: s = 8'hA0;
         8'h78: s = 8'hA4;
         8'h79: s = 8'h64;
         8'h7A: s = 8'h2C;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

@@ src/hifd_front.sv @@
// request front end: accepts transactions and decodes them into field updates
module hifd_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hifd_pkg::req_type    req_data,
   input  hifd_pkg::q_stat_type q_stat,
   output logic                 push,
   output hifd_pkg::cmd_type    cmd
);

   logic signed [7:0] fl;
   logic [7:0]        neg_val;
   logic [6:0]        u;
   logic [14:0]       tens_prod;
   logic [3:0]        tens;
   logic [6:0]        units_full;
   logic [3:0]        units;
   logic [hifd_pkg::LAMP_W-1:0] sel_bit;

   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      fl         = req_data.floor_number;
      neg_val    = -fl;
      u          = fl[6:0];
      // divide by ten as multiply by 205 and shift, exact below 100
      tens_prod  = 15'(u) * 15'd205;
      tens       = tens_prod[14:11];
      units_full = u - 7'(tens * 4'd10);
      units      = units_full[3:0];

      case (req_data.lamp_select)
         hifd_pkg::SEL_ANIM:     sel_bit = 6'b010000;
         hifd_pkg::SEL_FAST:     sel_bit = 6'b100000;
         hifd_pkg::SEL_OVERLOAD: sel_bit = 6'b000100;
         default:                sel_bit = 6'b001000;
      endcase

      cmd           = '0;
      cmd.raw_frame = {req_data.raw_lamp, req_data.raw_left, req_data.raw_right};

      unique case (req_data.func)
         hifd_pkg::FUNC_RAW: begin
            cmd.cmd     = 1'b1;
            cmd.use_raw = 1'b1;
         end
         hifd_pkg::FUNC_ARROW: begin
            cmd.cmd       = 1'b1;
            cmd.lamp_mask = 6'b000011;
            if (req_data.arrow_dir == hifd_pkg::DIR_UP) begin
               cmd.lamp_val = 6'b000001;
            end else if (req_data.arrow_dir == hifd_pkg::DIR_DOWN) begin
               cmd.lamp_val = 6'b000010;
            end
         end
         hifd_pkg::FUNC_LAMP: begin
            cmd.cmd       = 1'b1;
            cmd.lamp_mask = sel_bit;
            // fast animation lamp is active low
            if ((req_data.lamp_select == hifd_pkg::SEL_FAST) ? !req_data.flag
                                                             : req_data.flag) begin
               cmd.lamp_val = sel_bit;
            end
         end
         hifd_pkg::FUNC_FLOOR: begin
            cmd.cmd       = 1'b1;
            cmd.floor_bad = (fl > 8'sd99) || (fl < -8'sd9);
            cmd.left_we   = 1'b1;
            cmd.right_we  = 1'b1;
            if (fl < 8'sd0) begin
               cmd.left_val  = hifd_pkg::LEFT_ALL;
               cmd.right_val = hifd_pkg::digit_seg(neg_val[3:0]);
            end else begin
               cmd.left_val  = (tens == 4'd0) ? '0 : 11'(hifd_pkg::digit_seg(tens));
               cmd.right_val = hifd_pkg::digit_seg(units);
            end
         end
         hifd_pkg::FUNC_ASCII: begin
            cmd.cmd       = 1'b1;
            cmd.left_we   = req_data.left_char != 8'd0;
            cmd.left_val  = 11'(hifd_pkg::char_seg(req_data.left_char));
            cmd.right_we  = req_data.right_char != 8'd0;
            cmd.right_val = hifd_pkg::char_seg(req_data.right_char);
         end
         hifd_pkg::FUNC_CLEAR: begin
            cmd.cmd       = 1'b1;
            cmd.lamp_mask = '1;
            cmd.left_we   = 1'b1;
            cmd.right_we  = 1'b1;
         end
         default: begin
            cmd.cmd = 1'b0;
         end
      endcase
   end

endmodule

@@ src/hifd_queue.sv @@
// short command queue between the decode front and the frame engine
`include "assert_macros.svh"

module hifd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hifd_pkg::cmd_type    din,
   input  logic                 pop,
   output hifd_pkg::cmd_type    dout,
   output hifd_pkg::q_stat_type stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   hifd_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout       = slot_ff[rd_ptr_ff];
   assign stat.full  = count_ff == CNT_W'(DEPTH);
   assign stat.empty = count_ff == '0;

   `HIFD_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue overfilled")
   `HIFD_ASSERT_IMP(a_ptr_gap, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "empty queue pointers apart")

endmodule

@@ src/hifd_back.sv @@
// frame engine: field store, link sequencer and registered result stage
`include "assert_macros.svh"

module hifd_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   output logic                             item_ready,
   input  hifd_pkg::cmd_type                item,
   input  logic                             csr_write_en,
   input  logic                             csr_index,
   input  logic [hifd_pkg::HALF_W-1:0]      csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output hifd_pkg::rsp_type                rsp_data
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_SETUP,
      PH_HIGH,
      PH_LOW,
      PH_COMMIT,
      PH_PULSE
   } phase_type;

   typedef struct packed {
      phase_type                            phase;
      logic [hifd_pkg::TIMER_W-1:0]         timer;
      logic [hifd_pkg::BIT_CNT_W-1:0]       bits;
   } seq_type;

   // enter a phase, skipping phases of zero length
   function automatic seq_type enter_phase(
      input phase_type                       target,
      input logic [hifd_pkg::BIT_CNT_W-1:0]  bits_in,
      input logic [hifd_pkg::HALF_W-1:0]     half,
      input logic [hifd_pkg::PULSE_W-1:0]    pulse
   );
      seq_type                       s;
      seq_type                       to_pulse;
      logic [hifd_pkg::TIMER_W-1:0]  two_half;
      logic [hifd_pkg::TIMER_W-1:0]  one_half;
      logic [hifd_pkg::TIMER_W-1:0]  low_len;
      two_half       = {half, 1'b0};
      one_half       = {1'b0, half};
      low_len        = {2'b00, half[hifd_pkg::HALF_W-1:1]};
      to_pulse.phase = (pulse != '0) ? PH_PULSE : PH_IDLE;
      to_pulse.timer = {1'b0, pulse};
      to_pulse.bits  = bits_in;
      s.phase = target;
      s.timer = '0;
      s.bits  = bits_in;
      case (target)
         PH_LEAD, PH_SETUP, PH_HIGH: begin
            if (half == '0) begin
               // every bit phase collapses, the last bit stays on data
               s      = to_pulse;
               s.bits = hifd_pkg::BIT_CNT_W'(1);
            end else begin
               s.timer = (target == PH_LEAD) ? two_half : one_half;
            end
         end
         PH_LOW: begin
            if (half == '0) begin
               s      = to_pulse;
               s.bits = hifd_pkg::BIT_CNT_W'(1);
            end else if (low_len == '0) begin
               if (bits_in > hifd_pkg::BIT_CNT_W'(1)) begin
                  s.phase = PH_SETUP;
                  s.bits  = bits_in - 1'b1;
                  s.timer = one_half;
               end else begin
                  s.phase = PH_COMMIT;
                  s.timer = two_half;
               end
            end else begin
               s.timer = low_len;
            end
         end
         PH_COMMIT: begin
            if (half == '0) begin
               s = to_pulse;
            end else begin
               s.timer = two_half;
            end
         end
         PH_PULSE: begin
            s = to_pulse;
         end
         default: begin
            s.phase = PH_IDLE;
            s.timer = '0;
         end
      endcase
      return s;
   endfunction

   phase_type                               phase_ff;
   logic [hifd_pkg::TIMER_W-1:0]            timer_ff;
   logic [hifd_pkg::BIT_CNT_W-1:0]          bits_ff;
   logic [hifd_pkg::FRAME_BITS-1:0]         shift_ff, shift_in;
   logic [hifd_pkg::LAMP_W-1:0]             lamp_ff, lamp_in;
   logic [hifd_pkg::LEFT_W-1:0]             left_ff, left_in;
   logic [hifd_pkg::RIGHT_W-1:0]            right_ff, right_in;
   logic [hifd_pkg::HALF_W-1:0]             half_ff;
   logic [hifd_pkg::PULSE_W-1:0]            pulse_ff;
   logic                                    rsp_valid_ff;
   hifd_pkg::rsp_type                       rsp_data_ff, rsp_data_in;

   logic                                    step;
   logic                                    idle;
   logic                                    apply;
   logic [hifd_pkg::FRAME_BITS-1:0]         frame;
   seq_type                                 cur;
   seq_type                                 seq_in;
   phase_type                               nxt_phase;
   logic [hifd_pkg::BIT_CNT_W-1:0]          nxt_bits;
   logic [hifd_pkg::BIT_CNT_W-1:0]          bit_idx;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign step       = item_valid && item_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      idle  = phase_ff == PH_IDLE;
      apply = item.cmd && idle && !item.floor_bad;

      lamp_in  = lamp_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (apply) begin
         lamp_in = (lamp_ff & ~item.lamp_mask) | item.lamp_val;
         if (item.left_we) begin
            left_in = item.left_val;
         end
         if (item.right_we) begin
            right_in = item.right_val;
         end
      end
      frame = item.use_raw ? item.raw_frame : {lamp_in, left_in, right_in};

      cur.phase = phase_ff;
      cur.timer = timer_ff;
      cur.bits  = bits_ff;
      shift_in  = shift_ff;
      if (apply) begin
         cur      = enter_phase(PH_LEAD, '0, half_ff, pulse_ff);
         shift_in = frame;
      end

      // line levels for this tick
      bit_idx                 = cur.bits - 1'b1;
      rsp_data_in.data_line   = 1'b0;
      if (cur.phase != PH_IDLE && cur.phase != PH_LEAD && cur.bits != '0 &&
          cur.bits <= hifd_pkg::BIT_CNT_W'(hifd_pkg::FRAME_BITS)) begin
         rsp_data_in.data_line = shift_in[bit_idx];
      end
      rsp_data_in.clock_line  = cur.phase == PH_HIGH;
      rsp_data_in.enable_line = cur.phase != PH_PULSE;
      rsp_data_in.busy_res    = cur.phase != PH_IDLE;
      if (item.cmd && !idle) begin
         rsp_data_in.status = hifd_pkg::STATUS_BUSY;
      end else if (item.cmd && item.floor_bad) begin
         rsp_data_in.status = hifd_pkg::STATUS_RANGE;
      end else begin
         rsp_data_in.status = hifd_pkg::STATUS_OK;
      end

      // next phase once the current one runs out
      nxt_bits = cur.bits;
      case (cur.phase)
         PH_LEAD: begin
            nxt_phase = PH_SETUP;
            nxt_bits  = hifd_pkg::BIT_CNT_W'(hifd_pkg::FRAME_BITS);
         end
         PH_SETUP: nxt_phase = PH_HIGH;
         PH_HIGH:  nxt_phase = PH_LOW;
         PH_LOW: begin
            if (cur.bits > hifd_pkg::BIT_CNT_W'(1)) begin
               nxt_phase = PH_SETUP;
               nxt_bits  = cur.bits - 1'b1;
            end else begin
               nxt_phase = PH_COMMIT;
            end
         end
         PH_COMMIT: nxt_phase = PH_PULSE;
         default:   nxt_phase = PH_IDLE;
      endcase

      seq_in = cur;
      if (cur.phase != PH_IDLE) begin
         if (cur.timer == hifd_pkg::TIMER_W'(1)) begin
            seq_in = enter_phase(nxt_phase, nxt_bits, half_ff, pulse_ff);
         end else begin
            seq_in.timer = cur.timer - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         bits_ff      <= '0;
         shift_ff     <= '0;
         lamp_ff      <= hifd_pkg::LAMP_RESET;
         left_ff      <= '0;
         right_ff     <= '0;
         half_ff      <= hifd_pkg::HALF_RESET;
         pulse_ff     <= hifd_pkg::PULSE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == hifd_pkg::CSR_HALF_PERIOD) begin
               half_ff <= csr_wdata;
            end else begin
               pulse_ff <= csr_wdata;
            end
         end
         if (step) begin
            phase_ff <= seq_in.phase;
            timer_ff <= seq_in.timer;
            bits_ff  <= seq_in.bits;
            shift_ff <= shift_in;
            lamp_ff  <= lamp_in;
            left_ff  <= left_in;
            right_ff <= right_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `HIFD_ASSERT_IMP(a_busy_timer, clock, reset, phase_ff != PH_IDLE, timer_ff != '0, "active phase with empty timer")
   `HIFD_ASSERT_IMP(a_idle_timer, clock, reset, phase_ff == PH_IDLE, timer_ff == '0, "idle with timer running")
   `HIFD_ASSERT_ALWAYS(a_bit_range, clock, reset, bits_ff <= hifd_pkg::BIT_CNT_W'(hifd_pkg::FRAME_BITS), "bit count past frame")
   `HIFD_ASSERT_NXT(a_refused_hold, clock, reset, step && item.cmd && phase_ff != PH_IDLE, $stable(lamp_ff) && $stable(left_ff) && $stable(right_ff), "refused command changed fields")

endmodule

@@ src/hall_indicator_frame_driver.sv @@
// top level of the hall indicator frame driver
//
//   channel  ports                              direction  transaction
//   request  req_valid / req_ready / req_data   in         one tick or command
//   response rsp_valid / rsp_ready / rsp_data   out        line levels for that tick
//   control  csr_write_en / csr_index / csr_wdata in       half_period, enable_pulse
//
// one request transaction per clock while the queue has room; each request yields
// one response; the request is first registered in the command queue, then passes
// through the frame engine into the output register, which holds the response
// reset is synchronous; fields, timing registers and the sequencer reload at once
// a stalled response holds the frame engine; the queue then fills and req_ready drops
module hall_indicator_frame_driver #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  hifd_pkg::req_type           req_data,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output hifd_pkg::rsp_type           rsp_data,
   // register writes, index 0 half_period, index 1 enable_pulse
   input  logic                        csr_write_en,
   input  logic                        csr_index,
   input  logic [hifd_pkg::HALF_W-1:0] csr_wdata
);

   logic                 push;
   logic                 pop;
   logic                 item_ready;
   hifd_pkg::cmd_type    front_cmd;
   hifd_pkg::cmd_type    queue_cmd;
   hifd_pkg::q_stat_type q_stat;

   // decode: classify the command and work out segment patterns up front
   hifd_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .cmd       (front_cmd)
   );

   // decoupling queue between decode and the frame engine
   hifd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (front_cmd),
      .pop   (pop),
      .dout  (queue_cmd),
      .stat  (q_stat)
   );

   assign pop = !q_stat.empty && item_ready;

   // busy check, field update, frame sequencer and output register
   hifd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (!q_stat.empty),
      .item_ready   (item_ready),
      .item         (queue_cmd),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
